// ===== rtl/gsm_pkg.sv =====
package gsm_pkg;

  localparam int unsigned SLOT_COUNT = 64;
  localparam int unsigned ELEMENT_WIDTH = 32;

  localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
  localparam int unsigned LINK_W = IDX_W + 1;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned CMD_W = 2;
  localparam int unsigned STATUS_W = 2;

  localparam logic [LINK_W-1:0] SLOT_END = LINK_W'(SLOT_COUNT);
  localparam logic [STAMP_W-1:0] STAMP_FREE = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_GET    = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_STALE     = 2'd2,
    ST_EXHAUSTED = 2'd3
  } status_e;

  // Strobes from the sequencer to the datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic finish;
    logic load_out;
  } gsm_cmd_t;

endpackage

// ===== rtl/generational_slot_map_top.sv =====
// Channel  Handshake                Payload
// in       in_valid_i / in_ready_o   command_i, key_index_i, key_generation_i, new_element_i
// out      out_valid_o / out_ready_i status_o, out_index_o, out_generation_o,
//                                    out_element_o, live_count_o
//
// A beat passes in order through capture with slot table read, decide and update, dense
// move or element read, and load of the output register; the chain of dependent table
// reads and writes sets this sequence.
// After reset the block accepts a beat at once; no clearing pass is needed.
// A result held in the output register does not block the next beat; a third
// beat waits only while that register is still occupied.
module generational_slot_map_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [gsm_pkg::CMD_W-1:0]         command_i,
  input  logic [gsm_pkg::IDX_W-1:0]         key_index_i,
  input  logic [gsm_pkg::STAMP_W-1:0]       key_generation_i,
  input  logic [gsm_pkg::ELEMENT_WIDTH-1:0] new_element_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [gsm_pkg::STATUS_W-1:0]      status_o,
  output logic [gsm_pkg::IDX_W-1:0]         out_index_o,
  output logic [gsm_pkg::STAMP_W-1:0]       out_generation_o,
  output logic [gsm_pkg::ELEMENT_WIDTH-1:0] out_element_o,
  output logic [gsm_pkg::LINK_W-1:0]        live_count_o
);

  gsm_pkg::gsm_cmd_t cmd;

  gsm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  gsm_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .command_i        (command_i),
    .key_index_i      (key_index_i),
    .key_generation_i (key_generation_i),
    .new_element_i    (new_element_i),
    .status_o         (status_o),
    .out_index_o      (out_index_o),
    .out_generation_o (out_generation_o),
    .out_element_o    (out_element_o),
    .live_count_o     (live_count_o)
  );

endmodule

// ===== rtl/gsm_ram.sv =====
module gsm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/gsm_datapath.sv =====
module gsm_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  gsm_pkg::gsm_cmd_t                   cmd_i,
  input  logic [gsm_pkg::CMD_W-1:0]           command_i,
  input  logic [gsm_pkg::IDX_W-1:0]           key_index_i,
  input  logic [gsm_pkg::STAMP_W-1:0]         key_generation_i,
  input  logic [gsm_pkg::ELEMENT_WIDTH-1:0]   new_element_i,
  output logic [gsm_pkg::STATUS_W-1:0]        status_o,
  output logic [gsm_pkg::IDX_W-1:0]           out_index_o,
  output logic [gsm_pkg::STAMP_W-1:0]         out_generation_o,
  output logic [gsm_pkg::ELEMENT_WIDTH-1:0]   out_element_o,
  output logic [gsm_pkg::LINK_W-1:0]          live_count_o
);

  // Captured beat
  logic [gsm_pkg::CMD_W-1:0]         cmd_q;
  logic [gsm_pkg::IDX_W-1:0]         slot_q;
  logic [gsm_pkg::STAMP_W-1:0]       gen_q;
  logic [gsm_pkg::ELEMENT_WIDTH-1:0] elem_q;
  logic                              rd_valid_q;

  // Control state
  logic [gsm_pkg::LINK_W-1:0]  free_head_q, free_head_d;
  logic [gsm_pkg::LINK_W-1:0]  live_q, live_d;
  logic [gsm_pkg::STAMP_W-1:0] stamp_next_q, stamp_next_d;
  logic [gsm_pkg::SLOT_COUNT-1:0] written_q, written_d;
  logic do_move_q, do_move_d;
  logic do_get_q, do_get_d;

  // Result staging
  logic [gsm_pkg::IDX_W-1:0]         pos_q, pos_d;
  logic [gsm_pkg::STATUS_W-1:0]      res_status_q, res_status_d;
  logic [gsm_pkg::IDX_W-1:0]         res_index_q, res_index_d;
  logic [gsm_pkg::STAMP_W-1:0]       res_gen_q, res_gen_d;
  logic [gsm_pkg::ELEMENT_WIDTH-1:0] res_elem_q, res_elem_d;

  // Output register
  logic [gsm_pkg::STATUS_W-1:0]      out_status_q;
  logic [gsm_pkg::IDX_W-1:0]         out_index_q;
  logic [gsm_pkg::STAMP_W-1:0]       out_gen_q;
  logic [gsm_pkg::ELEMENT_WIDTH-1:0] out_elem_q;
  logic [gsm_pkg::LINK_W-1:0]        out_live_q;

  // Memory ports
  logic                              link_we;
  logic [gsm_pkg::IDX_W-1:0]         link_waddr;
  logic [gsm_pkg::LINK_W-1:0]        link_wdata, link_rdata;
  logic                              stamp_we;
  logic [gsm_pkg::STAMP_W-1:0]       stamp_wdata, stamp_rdata;
  logic                              dense_we;
  logic [gsm_pkg::IDX_W-1:0]         dense_waddr, dense_raddr;
  logic [gsm_pkg::ELEMENT_WIDTH-1:0] dval_wdata, dval_rdata;
  logic [gsm_pkg::IDX_W-1:0]         down_wdata, down_rdata;
  logic [gsm_pkg::IDX_W-1:0]         slot_raddr;

  logic [gsm_pkg::LINK_W-1:0]  link_val;
  logic [gsm_pkg::STAMP_W-1:0] stamp_val;
  logic [gsm_pkg::LINK_W-1:0]  last_pos;
  logic                        hit;

  assign slot_raddr = (command_i == gsm_pkg::CMD_ADD) ?
                      free_head_q[gsm_pkg::IDX_W-1:0] : key_index_i;

  // A slot never written reads as its reset value
  assign link_val  = rd_valid_q ? link_rdata :
                     ({1'b0, slot_q} + gsm_pkg::LINK_W'(1));
  assign stamp_val = rd_valid_q ? stamp_rdata : gsm_pkg::STAMP_FREE;
  assign hit       = (stamp_val != gsm_pkg::STAMP_FREE) && (stamp_val == gen_q);
  assign last_pos  = live_q - gsm_pkg::LINK_W'(1);

  always_comb begin
    free_head_d  = free_head_q;
    live_d       = live_q;
    stamp_next_d = stamp_next_q;
    written_d    = written_q;
    do_move_d    = do_move_q;
    do_get_d     = do_get_q;
    pos_d        = pos_q;
    res_status_d = res_status_q;
    res_index_d  = res_index_q;
    res_gen_d    = res_gen_q;
    res_elem_d   = res_elem_q;
    link_we      = 1'b0;
    link_waddr   = slot_q;
    link_wdata   = live_q;
    stamp_we     = 1'b0;
    stamp_wdata  = stamp_next_q;
    dense_we     = 1'b0;
    dense_waddr  = live_q[gsm_pkg::IDX_W-1:0];
    dense_raddr  = last_pos[gsm_pkg::IDX_W-1:0];
    dval_wdata   = elem_q;
    down_wdata   = slot_q;

    if (cmd_i.exec) begin
      do_move_d    = 1'b0;
      do_get_d     = 1'b0;
      res_status_d = gsm_pkg::ST_OK;
      res_index_d  = '0;
      res_gen_d    = '0;
      res_elem_d   = '0;
      case (cmd_q)
        gsm_pkg::CMD_ADD: begin
          if ((live_q >= gsm_pkg::SLOT_END) || (free_head_q >= gsm_pkg::SLOT_END)) begin
            res_status_d = gsm_pkg::ST_FULL;
          end else if (stamp_next_q == gsm_pkg::STAMP_FREE) begin
            res_status_d = gsm_pkg::ST_EXHAUSTED;
          end else begin
            link_we            = 1'b1;
            stamp_we           = 1'b1;
            dense_we           = 1'b1;
            written_d[slot_q]  = 1'b1;
            free_head_d        = link_val;
            res_index_d        = slot_q;
            res_gen_d          = stamp_next_q;
            stamp_next_d       = stamp_next_q + gsm_pkg::STAMP_W'(1);
            live_d             = live_q + gsm_pkg::LINK_W'(1);
          end
        end
        gsm_pkg::CMD_REMOVE: begin
          if (!hit || (live_q == '0)) begin
            res_status_d = gsm_pkg::ST_STALE;
          end else begin
            link_we           = 1'b1;
            link_wdata        = free_head_q;
            stamp_we          = 1'b1;
            stamp_wdata       = gsm_pkg::STAMP_FREE;
            written_d[slot_q] = 1'b1;
            free_head_d       = {1'b0, slot_q};
            live_d            = last_pos;
            // Fill the hole with the last dense entry
            if ((link_val != last_pos) && (link_val < gsm_pkg::SLOT_END)) begin
              do_move_d = 1'b1;
              pos_d     = link_val[gsm_pkg::IDX_W-1:0];
            end
          end
        end
        gsm_pkg::CMD_GET: begin
          if (!hit) begin
            res_status_d = gsm_pkg::ST_STALE;
          end else if (link_val < gsm_pkg::SLOT_END) begin
            do_get_d    = 1'b1;
            dense_raddr = link_val[gsm_pkg::IDX_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd_i.finish) begin
      if (do_move_q) begin
        dense_we    = 1'b1;
        dense_waddr = pos_q;
        dval_wdata  = dval_rdata;
        down_wdata  = down_rdata;
        link_we     = 1'b1;
        link_waddr  = down_rdata;
        link_wdata  = {1'b0, pos_q};
      end
      if (do_get_q) begin
        res_elem_d = dval_rdata;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q  <= '0;
      live_q       <= '0;
      stamp_next_q <= '0;
      written_q    <= '0;
      do_move_q    <= 1'b0;
      do_get_q     <= 1'b0;
    end else begin
      free_head_q  <= free_head_d;
      live_q       <= live_d;
      stamp_next_q <= stamp_next_d;
      written_q    <= written_d;
      do_move_q    <= do_move_d;
      do_get_q     <= do_get_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q      <= command_i;
      slot_q     <= slot_raddr;
      gen_q      <= key_generation_i;
      elem_q     <= new_element_i;
      rd_valid_q <= written_q[slot_raddr];
    end
    pos_q        <= pos_d;
    res_status_q <= res_status_d;
    res_index_q  <= res_index_d;
    res_gen_q    <= res_gen_d;
    res_elem_q   <= res_elem_d;
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_index_q  <= res_index_q;
      out_gen_q    <= res_gen_q;
      out_elem_q   <= res_elem_q;
      out_live_q   <= live_q;
    end
  end

  gsm_ram #(
    .WIDTH (gsm_pkg::LINK_W),
    .DEPTH (gsm_pkg::SLOT_COUNT)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (slot_raddr),
    .rdata_o (link_rdata)
  );

  gsm_ram #(
    .WIDTH (gsm_pkg::STAMP_W),
    .DEPTH (gsm_pkg::SLOT_COUNT)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (stamp_we),
    .waddr_i (slot_q),
    .wdata_i (stamp_wdata),
    .raddr_i (slot_raddr),
    .rdata_o (stamp_rdata)
  );

  gsm_ram #(
    .WIDTH (gsm_pkg::ELEMENT_WIDTH),
    .DEPTH (gsm_pkg::SLOT_COUNT)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (dense_we),
    .waddr_i (dense_waddr),
    .wdata_i (dval_wdata),
    .raddr_i (dense_raddr),
    .rdata_o (dval_rdata)
  );

  gsm_ram #(
    .WIDTH (gsm_pkg::IDX_W),
    .DEPTH (gsm_pkg::SLOT_COUNT)
  ) u_owner_ram (
    .clk_i   (clk_i),
    .we_i    (dense_we),
    .waddr_i (dense_waddr),
    .wdata_i (down_wdata),
    .raddr_i (dense_raddr),
    .rdata_o (down_rdata)
  );

  assign status_o         = out_status_q;
  assign out_index_o      = out_index_q;
  assign out_generation_o = out_gen_q;
  assign out_element_o    = out_elem_q;
  assign live_count_o     = out_live_q;

endmodule

// ===== rtl/gsm_ctrl.sv =====
module gsm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output gsm_pkg::gsm_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_FIN  = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    out_valid_d   = out_valid_q;
    in_ready_o    = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_FIN;
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = S_EMIT;
      end
      S_EMIT: begin
        // Hold the result until the output register frees up
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
